// ----- src/gnsc_pkg.sv -----
// Shared constants and types of the Go-Back-N sender control unit.
package gnsc_pkg;

    localparam int unsigned MAX_WINDOW = 32;
    localparam int unsigned WIN_W = 6;

    // input commands
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // packet types
    localparam logic [1:0] PKT_START = 2'd0;
    localparam logic [1:0] PKT_END   = 2'd1;
    localparam logic [1:0] PKT_DATA  = 2'd2;
    localparam logic [1:0] PKT_ACK   = 2'd3;

    // phase codes, reported as status
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HANDSHAKE = 3'd1;
    localparam logic [2:0] PH_DATA      = 3'd2;
    localparam logic [2:0] PH_CLOSING   = 3'd3;
    localparam logic [2:0] PH_DONE      = 3'd4;
    localparam logic [2:0] PH_FAILED    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_WINDOW   = 3'd0;
    localparam logic [2:0] REG_TOTAL    = 3'd1;
    localparam logic [2:0] REG_STARTSEQ = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_ATTEMPTS = 3'd4;

    // configuration reset values
    localparam logic [WIN_W-1:0] WINDOW_RST  = 6'd8;
    localparam logic [15:0]      TIMEOUT_RST = 16'd500;
    localparam logic [7:0]       ATTEMPT_RST = 8'd10;

    // what the emit step sends
    typedef enum logic [1:0] {
        EMIT_NONE  = 2'd0,
        EMIT_START = 2'd1,
        EMIT_END   = 2'd2,
        EMIT_DATA  = 2'd3
    } emit_kind_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic adv;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_adv;
        logic out_free;
        logic emit_last;
    } dp_sts_t;

endpackage

// ----- src/gnsc_ctrl.sv -----
// Sequencer of the sender control unit: evaluate, advance window, emit results.
module gnsc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gnsc_pkg::dp_sts_t sts,
    output gnsc_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_ADV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.need_adv ? ST_ADV : ST_EMIT;
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.out_free && sts.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/gnsc_datapath.sv -----
// Datapath of the sender control unit: configuration, window state, timer, result register.
module gnsc_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic [1:0]        s_command,
    input  logic [1:0]        s_rx_type,
    input  logic [31:0]       s_rx_seq,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_tx_valid,
    output logic [1:0]        m_tx_type,
    output logic [31:0]       m_tx_seq,
    output logic [2:0]        m_status,
    output logic              m_last,
    input  gnsc_pkg::dp_cmd_t cmd,
    output gnsc_pkg::dp_sts_t sts
);

    localparam int unsigned WW = gnsc_pkg::WIN_W;

    logic [WW-1:0] window_reg;
    logic [31:0]   total_reg;
    logic [31:0]   startseq_reg;
    logic [15:0]   timeout_reg;
    logic [7:0]    attempts_cfg_reg;

    logic [1:0]    in_cmd_reg;
    logic [1:0]    in_type_reg;
    logic [31:0]   in_seq_reg;

    logic [2:0]    phase_reg, phase_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   next_reg, next_next;
    logic          timer_reg, timer_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic [7:0]    attempts_reg, attempts_next;
    gnsc_pkg::emit_kind_t kind_reg, kind_next;
    logic          need_adv;

    logic          out_valid_reg, out_valid_next;
    logic          out_txv_reg, out_txv_next;
    logic [1:0]    out_type_reg, out_type_next;
    logic [31:0]   out_seq_reg, out_seq_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;

    logic [WW-1:0] win_eff;
    logic [15:0]   timeout_eff;
    logic [7:0]    attempts_lim;
    logic [15:0]   tick_inc;
    logic          expired;
    logic [32:0]   win_edge;
    logic [32:0]   next_inc;
    logic          send_cur;
    logic          send_inc;
    logic          out_free;
    logic          ack_ok;

    assign cfg_ready = 1'b1;

    assign win_eff = (window_reg == '0) ? WW'(1) :
                     (window_reg > WW'(gnsc_pkg::MAX_WINDOW)) ? WW'(gnsc_pkg::MAX_WINDOW) :
                     window_reg;
    assign timeout_eff  = (timeout_reg == '0) ? 16'd1 : timeout_reg;
    assign attempts_lim = (attempts_cfg_reg == '0) ? 8'd1 : attempts_cfg_reg;
    assign tick_inc     = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign expired      = (tick_inc >= timeout_eff);

    assign win_edge = {1'b0, base_reg} + {{(33-WW){1'b0}}, win_eff};
    assign next_inc = {1'b0, next_reg} + 33'd1;
    assign send_cur = ({1'b0, next_reg} < win_edge) && (next_reg < total_reg);
    assign send_inc = (next_inc < win_edge) && (next_inc < {1'b0, total_reg});
    assign out_free = !out_valid_reg || m_ready;
    assign ack_ok   = (in_type_reg == gnsc_pkg::PKT_ACK) && (in_seq_reg == startseq_reg);

    assign sts.need_adv  = need_adv;
    assign sts.out_free  = out_free;
    assign sts.emit_last = (kind_reg != gnsc_pkg::EMIT_DATA) || !send_inc;

    always_comb begin
        phase_next      = phase_reg;
        base_next       = base_reg;
        next_next       = next_reg;
        timer_next      = timer_reg;
        elapsed_next    = elapsed_reg;
        attempts_next   = attempts_reg;
        kind_next       = kind_reg;
        need_adv        = 1'b0;
        out_valid_next  = out_valid_reg && !m_ready;
        out_txv_next    = out_txv_reg;
        out_type_next   = out_type_reg;
        out_seq_next    = out_seq_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (cmd.eval) begin
            kind_next = gnsc_pkg::EMIT_NONE;
            case (in_cmd_reg)
                gnsc_pkg::CMD_BEGIN: begin
                    if (phase_reg == gnsc_pkg::PH_IDLE || phase_reg == gnsc_pkg::PH_DONE ||
                        phase_reg == gnsc_pkg::PH_FAILED) begin
                        phase_next    = gnsc_pkg::PH_HANDSHAKE;
                        attempts_next = 8'd1;
                        base_next     = '0;
                        next_next     = '0;
                        timer_next    = 1'b1;
                        elapsed_next  = '0;
                        kind_next     = gnsc_pkg::EMIT_START;
                    end
                end
                gnsc_pkg::CMD_TICK: begin
                    if (timer_reg && (phase_reg == gnsc_pkg::PH_HANDSHAKE ||
                        phase_reg == gnsc_pkg::PH_DATA || phase_reg == gnsc_pkg::PH_CLOSING)) begin
                        elapsed_next = tick_inc;
                    end
                    if (phase_reg == gnsc_pkg::PH_HANDSHAKE) begin
                        if (timer_reg && expired) begin
                            if (attempts_reg >= attempts_lim) begin
                                phase_next   = gnsc_pkg::PH_FAILED;
                                timer_next   = 1'b0;
                                elapsed_next = '0;
                            end else begin
                                attempts_next = attempts_reg + 8'd1;
                                timer_next    = 1'b1;
                                elapsed_next  = '0;
                                kind_next     = gnsc_pkg::EMIT_START;
                            end
                        end
                    end else if (phase_reg == gnsc_pkg::PH_DATA) begin
                        need_adv = 1'b1;
                        if (timer_reg && expired) begin
                            next_next    = base_reg;
                            timer_next   = 1'b0;
                            elapsed_next = '0;
                        end
                    end else if (phase_reg == gnsc_pkg::PH_CLOSING) begin
                        if (timer_reg && expired) begin
                            timer_next   = 1'b1;
                            elapsed_next = '0;
                            kind_next    = gnsc_pkg::EMIT_END;
                        end
                    end
                end
                gnsc_pkg::CMD_RX: begin
                    if (phase_reg == gnsc_pkg::PH_HANDSHAKE) begin
                        if (ack_ok) begin
                            phase_next   = gnsc_pkg::PH_DATA;
                            base_next    = '0;
                            next_next    = '0;
                            timer_next   = 1'b0;
                            elapsed_next = '0;
                            need_adv     = 1'b1;
                        end
                    end else if (phase_reg == gnsc_pkg::PH_DATA) begin
                        need_adv = 1'b1;
                        if (in_type_reg == gnsc_pkg::PKT_ACK && in_seq_reg > base_reg) begin
                            if (in_seq_reg > next_reg) begin
                                // clamp to the highest number sent
                                if (next_reg > base_reg) begin
                                    base_next    = next_reg;
                                    timer_next   = 1'b0;
                                    elapsed_next = '0;
                                end
                            end else begin
                                base_next    = in_seq_reg;
                                timer_next   = (in_seq_reg < next_reg);
                                elapsed_next = '0;
                            end
                        end
                    end else if (phase_reg == gnsc_pkg::PH_CLOSING) begin
                        if (ack_ok) begin
                            phase_next   = gnsc_pkg::PH_DONE;
                            timer_next   = 1'b0;
                            elapsed_next = '0;
                        end
                    end
                end
                default: begin
                    kind_next = gnsc_pkg::EMIT_NONE;
                end
            endcase
        end

        if (cmd.adv) begin
            if (base_reg >= total_reg) begin
                phase_next   = gnsc_pkg::PH_CLOSING;
                kind_next    = gnsc_pkg::EMIT_END;
                timer_next   = 1'b1;
                elapsed_next = '0;
            end else if (send_cur) begin
                kind_next = gnsc_pkg::EMIT_DATA;
                if (next_reg == base_reg) begin
                    timer_next   = 1'b1;
                    elapsed_next = '0;
                end
            end else begin
                kind_next = gnsc_pkg::EMIT_NONE;
            end
        end

        if (cmd.emit && out_free) begin
            out_valid_next  = 1'b1;
            out_status_next = phase_reg;
            out_last_next   = 1'b1;
            case (kind_reg)
                gnsc_pkg::EMIT_START: begin
                    out_txv_next  = 1'b1;
                    out_type_next = gnsc_pkg::PKT_START;
                    out_seq_next  = startseq_reg;
                end
                gnsc_pkg::EMIT_END: begin
                    out_txv_next  = 1'b1;
                    out_type_next = gnsc_pkg::PKT_END;
                    out_seq_next  = startseq_reg;
                end
                gnsc_pkg::EMIT_DATA: begin
                    out_txv_next  = 1'b1;
                    out_type_next = gnsc_pkg::PKT_DATA;
                    out_seq_next  = next_reg;
                    out_last_next = !send_inc;
                    next_next     = next_inc[31:0];
                end
                default: begin
                    out_txv_next  = 1'b0;
                    out_type_next = '0;
                    out_seq_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= gnsc_pkg::WINDOW_RST;
            total_reg        <= '0;
            startseq_reg     <= '0;
            timeout_reg      <= gnsc_pkg::TIMEOUT_RST;
            attempts_cfg_reg <= gnsc_pkg::ATTEMPT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                gnsc_pkg::REG_WINDOW:   window_reg       <= cfg_data[WW-1:0];
                gnsc_pkg::REG_TOTAL:    total_reg        <= cfg_data;
                gnsc_pkg::REG_STARTSEQ: startseq_reg     <= cfg_data;
                gnsc_pkg::REG_TIMEOUT:  timeout_reg      <= cfg_data[15:0];
                gnsc_pkg::REG_ATTEMPTS: attempts_cfg_reg <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_cmd_reg  <= s_command;
            in_type_reg <= s_rx_type;
            in_seq_reg  <= s_rx_seq;
        end
        out_txv_reg    <= out_txv_next;
        out_type_reg   <= out_type_next;
        out_seq_reg    <= out_seq_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= gnsc_pkg::PH_IDLE;
            base_reg      <= '0;
            next_reg      <= '0;
            timer_reg     <= 1'b0;
            elapsed_reg   <= '0;
            attempts_reg  <= '0;
            kind_reg      <= gnsc_pkg::EMIT_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            timer_reg     <= timer_next;
            elapsed_reg   <= elapsed_next;
            attempts_reg  <= attempts_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_tx_valid = out_txv_reg;
    assign m_tx_type  = out_type_reg;
    assign m_tx_seq   = out_seq_reg;
    assign m_status   = out_status_reg;
    assign m_last     = out_last_reg;

endmodule

// ----- src/go_back_n_sender_control_unit.sv -----
// Top level of the Go-Back-N sender control unit.
// Sequence: a transaction is accepted in idle, evaluated, then the window is advanced when
// needed, and its results are then emitted into the output register.
// Throughput: one send request per cycle from the emit sequencer while the output is not stalled;
// no new transaction is accepted until all results of the current one have been emitted.
// Reset: synchronous, active low; phase idle, window and timer cleared, registers to defaults.
module go_back_n_sender_control_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [1:0]  s_rx_type,
    input  logic [31:0] s_rx_seq,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tx_valid,
    output logic [1:0]  m_tx_type,
    output logic [31:0] m_tx_seq,
    output logic [2:0]  m_status,
    output logic        m_last
);

    gnsc_pkg::dp_cmd_t cmd;
    gnsc_pkg::dp_sts_t sts;

    gnsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gnsc_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_command  (s_command),
        .s_rx_type  (s_rx_type),
        .s_rx_seq   (s_rx_seq),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_valid (m_tx_valid),
        .m_tx_type  (m_tx_type),
        .m_tx_seq   (m_tx_seq),
        .m_status   (m_status),
        .m_last     (m_last),
        .cmd        (cmd),
        .sts        (sts)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    a_partial_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready before all results of a transaction were produced");

    a_status_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_last)
        else $error("status-only result not marked last");

    a_data_in_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tx_valid && m_tx_type == gnsc_pkg::PKT_DATA
            |-> m_status == gnsc_pkg::PH_DATA)
        else $error("DATA request outside data phase");

endmodule
